>>> design/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared types and constants of the robot command frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfp_pkg;

  typedef enum logic [2:0] {
    EvShutdown = 3'd0,
    EvManual   = 3'd1,
    EvAngle    = 3'd2,
    EvWaypoint = 3'd3,
    EvReinit   = 3'd4
  } rcfp_event_e;

  typedef struct packed {
    rcfp_event_e        event_kind;
    logic               auto_mode;
    logic signed [13:0] velocity_milli;
    logic signed [15:0] turn_rate_tenk;
    logic signed [18:0] angle_rad_q16;
    logic        [4:0]  waypoint_index;
    logic signed [32:0] longitude_code;
    logic signed [32:0] latitude_code;
  } rcfp_result_t;

  localparam int InDataWidth  = 8;
  localparam int OutDataWidth = 128;
  localparam int OutUserWidth = 3;

endpackage

`default_nettype wire

>>> design/robot_command_frame_parser_top.sv
// ----------------------------------------------------------------------------
// robot_command_frame_parser_top
// Parses a telecommand byte stream into drive, angle and waypoint events.
// ----------------------------------------------------------------------------
// Input channel s_axis: one received byte per word in tdata[7:0]; tuser is
// set on the first byte of each command buffer.
// Output channel m_axis: one event per word; tuser carries the event kind,
// tdata the mode flag and the scaled values of that event (others zero).
// The parser handles each word as it leaves the input register; its event
// is then registered in the result register.
// Throughput: one byte per cycle unless m_axis stalls, set by the input
// register, the single pass through the FSM and the result register.
// Most bytes produce no event; at most one event per byte.
// Reset clears the valid flags of both registers and returns the parser to idle in auto mode.
// A stalled receiver holds the event in the result register; one more byte
// waits in the input register, then s_axis_tready drops until m_axis drains.
// ----------------------------------------------------------------------------
`default_nettype none

module robot_command_frame_parser_top
  import rcfp_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [InDataWidth-1:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic                    s_axis_tuser,  // [0] buffer_start
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // [0] auto_mode, [14:1] velocity_milli, [30:15] turn_rate_tenk,
  // [49:31] angle_rad_q16, [54:50] waypoint_index, [87:55] longitude_code,
  // [120:88] latitude_code, [127:121] zero
  output logic [OutDataWidth-1:0]      m_axis_tdata,
  output logic [OutUserWidth-1:0]      m_axis_tuser   // [2:0] event_kind
);

  logic         down_ready;
  logic         advance;
  logic [7:0]   data_byte;
  logic         buffer_start;
  logic         res_valid;
  rcfp_result_t res;
  rcfp_result_t res_out;

  rcfp_in_reg u_in_reg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_valid_i        (s_axis_tvalid),
    .s_data_byte_i    (s_axis_tdata),
    .s_buffer_start_i (s_axis_tuser),
    .down_ready_i     (down_ready),
    .s_ready_o        (s_axis_tready),
    .advance_o        (advance),
    .data_byte_o      (data_byte),
    .buffer_start_o   (buffer_start)
  );

  rcfp_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .data_byte_i    (data_byte),
    .buffer_start_i (buffer_start),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  rcfp_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance),
    .valid_i   (res_valid),
    .res_i     (res),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .res_o     (res_out),
    .ready_o   (down_ready)
  );

  assign m_axis_tuser = res_out.event_kind;
  assign m_axis_tdata = {7'd0,
                         res_out.latitude_code,
                         res_out.longitude_code,
                         res_out.waypoint_index,
                         res_out.angle_rad_q16,
                         res_out.turn_rate_tenk,
                         res_out.velocity_milli,
                         res_out.auto_mode};

endmodule

`default_nettype wire

>>> design/rcfp_in_reg.sv
// ----------------------------------------------------------------------------
// rcfp_in_reg
// Input register: holds one received word until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_in_reg
  import rcfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  input  wire logic [7:0] s_data_byte_i,
  input  wire logic       s_buffer_start_i,
  input  wire logic       down_ready_i,
  output logic            s_ready_o,
  output logic            advance_o,
  output logic [7:0]      data_byte_o,
  output logic            buffer_start_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       start_q;
  logic       take;

  assign advance_o      = valid_q && down_ready_i;
  assign s_ready_o      = !valid_q || advance_o;
  assign take           = s_valid_i && s_ready_o;
  assign data_byte_o    = data_q;
  assign buffer_start_o = start_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q  <= s_data_byte_i;
      start_q <= s_buffer_start_i;
    end
  end

endmodule

`default_nettype wire

>>> design/rcfp_parser.sv
// ----------------------------------------------------------------------------
// rcfp_parser
// Frame state machine: sync, function decode, field assembly and scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_parser
  import rcfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       advance_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       buffer_start_i,
  output logic            res_valid_o,
  output rcfp_result_t    res_o
);

  localparam logic [3:0] PhIdle    = 4'd0;
  localparam logic [3:0] PhSync2   = 4'd1;
  localparam logic [3:0] PhFunc    = 4'd2;
  localparam logic [3:0] PhMLen    = 4'd3;
  localparam logic [3:0] PhMVel    = 4'd4;
  localparam logic [3:0] PhMTurn   = 4'd5;
  localparam logic [3:0] PhASub    = 4'd6;
  localparam logic [3:0] PhALen    = 4'd7;
  localparam logic [3:0] PhAAng    = 4'd8;
  localparam logic [3:0] PhLonSign = 4'd9;
  localparam logic [3:0] PhLon     = 4'd10;
  localparam logic [3:0] PhLatSign = 4'd11;
  localparam logic [3:0] PhLat     = 4'd12;

  localparam logic [7:0] SyncByte   = 8'hAB;
  localparam logic [7:0] FnShutdown = 8'h00;
  localparam logic [7:0] FnManual   = 8'h01;
  localparam logic [7:0] FnAuto     = 8'h02;
  localparam logic [7:0] FnReinit   = 8'h03;
  localparam logic [7:0] SignNeg    = 8'h01;

  localparam int RecordBytes = 10;
  localparam int RecipShift  = 11;
  localparam int RecipMul    = (2 ** RecipShift + RecordBytes - 1) / RecordBytes;
  localparam logic [18:0] AngleScale  = 19'd411540;
  localparam logic signed [19:0] AngleOffset = 20'sd205770;

  logic [3:0]         phase_q, phase_d;
  logic [1:0]         count_q, count_d;
  logic [31:0]        word_q, word_d;
  logic               sign_q, sign_d;
  logic [7:0]         held_vel_q, held_vel_d;
  logic signed [32:0] held_lon_q, held_lon_d;
  logic [4:0]         left_q, left_d;
  logic [4:0]         wp_cnt_q, wp_cnt_d;
  logic               auto_q, auto_d;

  logic [7:0]         len_m2;
  logic [15:0]        recip_prod;
  logic [7:0]         quot_est;
  logic [7:0]         rem_est;
  logic [7:0]         quot;
  logic [15:0]        ang_word;
  logic [15:0]        ang_code;
  logic [34:0]        ang_prod;
  logic signed [19:0] ang_val;
  logic [31:0]        coord_word;
  logic signed [13:0] vel_val;
  logic signed [15:0] turn_val;

  function automatic logic signed [32:0] signed_coord(input logic [31:0] w, input logic neg);
    logic signed [32:0] v;
    v = $signed({w[31], w});
    return neg ? -v : v;
  endfunction

  assign len_m2     = data_byte_i - 8'd2;
  assign recip_prod = 16'(len_m2) * 16'(RecipMul);
  assign quot_est   = 8'(recip_prod >> RecipShift);
  assign rem_est    = len_m2 - 8'(quot_est * 8'(RecordBytes));
  assign quot       = (rem_est >= 8'(RecordBytes)) ? quot_est + 8'd1 : quot_est;

  assign ang_word = {data_byte_i, word_q[7:0]};
  assign ang_code = ang_word ^ 16'h8000;
  assign ang_prod = 35'(ang_code) * 35'(AngleScale);
  assign ang_val  = $signed({1'b0, ang_prod[34:16]}) - AngleOffset;

  assign coord_word = word_q | (32'(data_byte_i) << {count_q, 3'b000});
  assign vel_val    = $signed({{6{held_vel_q[7]}}, held_vel_q}) * 14'sd39;
  assign turn_val   = $signed({{8{data_byte_i[7]}}, data_byte_i}) * 16'sd156;

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    word_d      = word_q;
    sign_d      = sign_q;
    held_vel_d  = held_vel_q;
    held_lon_d  = held_lon_q;
    left_d      = left_q;
    wp_cnt_d    = wp_cnt_q;
    auto_d      = auto_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (advance_i) begin
      if (buffer_start_i) begin
        phase_d = (data_byte_i == SyncByte) ? PhSync2 : PhIdle;
      end else begin
        unique case (phase_q) inside
          PhSync2: begin
            phase_d = (data_byte_i == SyncByte) ? PhFunc : PhIdle;
          end
          PhFunc: begin
            phase_d = PhIdle;
            if (data_byte_i == FnShutdown || data_byte_i == FnReinit) begin
              res_valid_o      = 1'b1;
              res_o.event_kind = (data_byte_i == FnShutdown) ? EvShutdown : EvReinit;
              res_o.auto_mode  = auto_q;
            end else if (data_byte_i == FnManual) begin
              phase_d = PhMLen;
            end else if (data_byte_i == FnAuto) begin
              phase_d = PhASub;
            end
          end
          PhMLen: begin
            phase_d = PhMVel;
          end
          PhMVel: begin
            held_vel_d = data_byte_i;
            phase_d    = PhMTurn;
          end
          PhMTurn: begin
            auto_d               = 1'b0;
            phase_d              = PhIdle;
            res_valid_o          = 1'b1;
            res_o.event_kind     = EvManual;
            res_o.auto_mode      = 1'b0;
            res_o.velocity_milli = vel_val;
            res_o.turn_rate_tenk = turn_val;
          end
          PhASub: begin
            auto_d  = 1'b1;
            phase_d = (data_byte_i == 8'd0) ? PhALen : PhIdle;
          end
          PhALen: begin
            left_d  = (data_byte_i < 8'd2) ? 5'd0 : quot[4:0];
            count_d = 2'd0;
            phase_d = PhAAng;
          end
          PhAAng: begin
            if (count_q == 2'd0) begin
              word_d  = 32'(data_byte_i);
              count_d = 2'd1;
            end else begin
              word_d              = word_q | (32'(data_byte_i) << 8);
              count_d             = 2'd0;
              res_valid_o         = 1'b1;
              res_o.event_kind    = EvAngle;
              res_o.auto_mode     = auto_q;
              res_o.angle_rad_q16 = ang_val[18:0];
              wp_cnt_d            = 5'd0;
              phase_d             = (left_q == 5'd0) ? PhIdle : PhLonSign;
            end
          end
          PhLonSign, PhLatSign: begin
            sign_d  = (data_byte_i == SignNeg);
            count_d = 2'd0;
            word_d  = 32'd0;
            phase_d = (phase_q == PhLonSign) ? PhLon : PhLat;
          end
          PhLon, PhLat: begin
            word_d = coord_word;
            if (count_q != 2'd3) begin
              count_d = count_q + 2'd1;
            end else begin
              count_d = 2'd0;
              if (phase_q == PhLon) begin
                held_lon_d = signed_coord(coord_word, sign_q);
                phase_d    = PhLatSign;
              end else begin
                res_valid_o          = 1'b1;
                res_o.event_kind     = EvWaypoint;
                res_o.auto_mode      = auto_q;
                res_o.waypoint_index = wp_cnt_q;
                res_o.longitude_code = held_lon_q;
                res_o.latitude_code  = signed_coord(coord_word, sign_q);
                wp_cnt_d             = wp_cnt_q + 5'd1;
                left_d               = left_q - 5'd1;
                phase_d              = (left_q == 5'd1) ? PhIdle : PhLonSign;
              end
            end
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      count_q    <= 2'd0;
      word_q     <= 32'd0;
      sign_q     <= 1'b0;
      held_vel_q <= 8'd0;
      held_lon_q <= 33'sd0;
      left_q     <= 5'd0;
      wp_cnt_q   <= 5'd0;
      auto_q     <= 1'b1;
    end else begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      word_q     <= word_d;
      sign_q     <= sign_d;
      held_vel_q <= held_vel_d;
      held_lon_q <= held_lon_d;
      left_q     <= left_d;
      wp_cnt_q   <= wp_cnt_d;
      auto_q     <= auto_d;
    end
  end

  a_res_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> advance_i)
    else $error("result without a word");

  a_bad_sync_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && buffer_start_i && data_byte_i != SyncByte |=> phase_q == PhIdle)
    else $error("bad first sync byte did not return to idle");

  a_manual_clears_auto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.event_kind == EvManual |=> !auto_q)
    else $error("manual drive left auto mode set");

  a_waypoint_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhLonSign || phase_q == PhLatSign || phase_q == PhLon || phase_q == PhLat)
      |-> left_q != 5'd0)
    else $error("waypoint phase with no waypoints left");

endmodule

`default_nettype wire

>>> design/rcfp_out_reg.sv
// ----------------------------------------------------------------------------
// rcfp_out_reg
// Result register: holds one event until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_out_reg
  import rcfp_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire logic          valid_i,
  input  wire rcfp_result_t  res_i,
  input  wire logic          m_ready_i,
  output logic               m_valid_o,
  output rcfp_result_t       res_o,
  output logic               ready_o
);

  logic         valid_q, valid_d;
  rcfp_result_t res_q;

  assign m_valid_o = valid_q;
  assign res_o     = res_q;
  assign ready_o   = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = valid_i;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire
